// ===== rtl/ttc_pkg.sv =====
// Shared constants and types for the text console cursor control block.
package ttc_pkg;

  localparam int unsigned GEOM_W  = 8;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned TAB_W   = 3;  // log2 of the tab stop spacing of 8

  localparam logic [GEOM_W-1:0] COLUMNS_RST = 8'd80;
  localparam logic [GEOM_W-1:0] ROWS_RST    = 8'd25;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 1'd1;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [OP_W-1:0] OP_INVERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW   = 2'd1;
  localparam logic [OP_W-1:0] OP_SCROLL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] glyph;
    logic [GEOM_W-1:0] column;
    logic [GEOM_W-1:0] row;
    logic              last;
  } cell_cmd_t;

endpackage

// ===== rtl/text_console_cursor_control.sv =====
// Cursor sequencer: turns character words into ordered cell command words.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/stall   | in_char_code
//   out_    | output    | out_valid/stall  | out_cell_op, out_glyph_code, out_cell_column,
//           |           |                  | out_cell_row, out_last_of_run
//   cfg_    | input     | cfg_we           | cfg_index, cfg_wdata
//
// Each word is accepted and then emits 2 to 11 commands. The sequencer steps
// column, row and tab phase one cell per cycle while out_stall does not hold
// it, through a single increment-and-compare unit.
// Synchronous active-low reset restores 80 x 25 and homes the cursor.
// out_stall holds the sequencer on the current command; in_stall is high
// from acceptance until the final command has been registered.
module text_console_cursor_control
  import ttc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CHAR_W-1:0]    in_char_code,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OP_W-1:0]      out_cell_op,
  output logic [CHAR_W-1:0]    out_glyph_code,
  output logic [GEOM_W-1:0]    out_cell_column,
  output logic [GEOM_W-1:0]    out_cell_row,
  output logic                 out_last_of_run,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GEOM_W-1:0]    cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_TAB   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [GEOM_W-1:0] cols_r, cols_nxt;
  logic [GEOM_W-1:0] rows_r, rows_nxt;
  logic [GEOM_W-1:0] col_r, col_nxt;
  logic [GEOM_W-1:0] row_r, row_nxt;
  logic [TAB_W-1:0]  phase_r, phase_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              out_valid_r, out_valid_nxt;
  cell_cmd_t         cmd_r, cmd_nxt;

  logic              can_emit;
  logic              emit;
  logic              wrap;
  logic [GEOM_W-1:0] adv_col;
  logic [GEOM_W-1:0] adv_row;
  logic [TAB_W-1:0]  adv_phase;
  logic [GEOM_W-1:0] cfg_val;

  assign can_emit = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_val  = (cfg_wdata == '0) ? GEOM_W'(1) : cfg_wdata;

  // Shared step unit: advance one cell, wrapping to the next row.
  assign wrap      = (({1'b0, col_r} + 9'd1) == {1'b0, cols_r});
  assign adv_col   = wrap ? '0 : col_r + GEOM_W'(1);
  assign adv_row   = wrap ? row_r + GEOM_W'(1) : row_r;
  assign adv_phase = phase_r + TAB_W'(1);

  always_comb begin
    state_nxt  = state_r;
    cols_nxt   = cols_r;
    rows_nxt   = rows_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    phase_nxt  = phase_r;
    char_nxt   = char_r;
    emit       = 1'b0;
    cmd_nxt    = cmd_r;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          if (cfg_index == REG_TEXT_COLUMNS) cols_nxt = cfg_val;
          if (cfg_index == REG_TEXT_ROWS)    rows_nxt = cfg_val;
          col_nxt   = '0;
          row_nxt   = '0;
          phase_nxt = '0;
        end
        if (in_valid) begin
          char_nxt  = in_char_code;
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        if (can_emit) begin
          emit    = 1'b1;
          cmd_nxt = '{op: OP_INVERT, glyph: '0, column: col_r, row: row_r, last: 1'b0};
          state_nxt = S_CHECK;
          case (char_r)
            CH_NEWLINE: begin
              col_nxt   = '0;
              row_nxt   = row_r + GEOM_W'(1);
              phase_nxt = phase_r + cols_r[TAB_W-1:0] - col_r[TAB_W-1:0];
            end
            CH_RETURN: begin
              col_nxt   = '0;
              phase_nxt = phase_r - col_r[TAB_W-1:0];
            end
            CH_BACKSPACE: begin
              if (col_r != '0) begin
                col_nxt   = col_r - GEOM_W'(1);
                phase_nxt = phase_r - TAB_W'(1);
              end
            end
            CH_TAB: begin
              state_nxt = S_TAB;
            end
            default: begin
              cmd_nxt.op    = OP_DRAW;
              cmd_nxt.glyph = char_r;
              col_nxt       = adv_col;
              row_nxt       = adv_row;
              phase_nxt     = adv_phase;
            end
          endcase
        end
      end
      S_TAB: begin
        if (can_emit) begin
          emit      = 1'b1;
          cmd_nxt   = '{op: OP_DRAW, glyph: CH_SPACE, column: col_r, row: row_r, last: 1'b0};
          col_nxt   = adv_col;
          row_nxt   = adv_row;
          phase_nxt = adv_phase;
          // stop at a tab stop or once the screen has run out
          if (adv_phase == '0 || adv_row == rows_r) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (can_emit) begin
          emit = 1'b1;
          if (row_r == rows_r) begin
            cmd_nxt   = '{op: OP_SCROLL, glyph: '0, column: '0, row: '0, last: 1'b0};
            row_nxt   = rows_r - GEOM_W'(1);
            phase_nxt = phase_r - cols_r[TAB_W-1:0];
            state_nxt = S_LAST;
          end else begin
            cmd_nxt   = '{op: OP_INVERT, glyph: '0, column: col_r, row: row_r, last: 1'b1};
            state_nxt = S_IDLE;
          end
        end
      end
      S_LAST: begin
        if (can_emit) begin
          emit      = 1'b1;
          cmd_nxt   = '{op: OP_INVERT, glyph: '0, column: col_r, row: row_r, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // drop the word once taken unless a new one replaces it
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cols_r      <= COLUMNS_RST;
      rows_r      <= ROWS_RST;
      col_r       <= '0;
      row_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    cmd_r  <= cmd_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_cell_op     = cmd_r.op;
  assign out_glyph_code  = cmd_r.glyph;
  assign out_cell_column = cmd_r.column;
  assign out_cell_row    = cmd_r.row;
  assign out_last_of_run = cmd_r.last;

`ifndef SYNTH
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (col_r < cols_r))
    else $error("cursor column outside the screen");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (row_r < rows_r))
    else $error("cursor row outside the screen");

  a_scroll_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && cmd_r.op == OP_SCROLL) |-> (!cmd_r.last && state_r == S_LAST))
    else $error("scroll must be followed by the closing invert");

  a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && state_r != S_IDLE && state_nxt == S_IDLE) |=> (out_valid_r && cmd_r.last))
    else $error("run ended without a final command");
`endif

endmodule
